// ----- sv/shell_basis_reorder_index_defines.svh -----
// assertion macros for the shell basis reorder index block
`ifndef SHELL_BASIS_REORDER_INDEX_DEFINES_SVH
`define SHELL_BASIS_REORDER_INDEX_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SBRI_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sbri assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SBRI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sbri assertion failed");

`endif

// ----- sv/sbri_pkg.sv -----
// types, shell codes, permutation tables and microcode for the reorder index block
package sbri_pkg;

	localparam int REL_BITS = 6;

	localparam logic signed [4:0] TYPE_SP = -5'sd1;
	localparam logic signed [4:0] TYPE_S  = 5'sd0;
	localparam logic signed [4:0] TYPE_P  = 5'sd1;
	localparam logic signed [4:0] TYPE_D  = 5'sd2;
	localparam logic signed [4:0] TYPE_F  = 5'sd3;
	localparam logic signed [4:0] TYPE_G  = 5'sd4;

	typedef enum logic [2:0] {
		MODE_IDENT = 3'd0,
		MODE_PURE  = 3'd1,
		MODE_D     = 3'd2,
		MODE_F     = 3'd3,
		MODE_G     = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		COND_ALWAYS = 2'd0,
		COND_ACCEPT = 2'd1,
		COND_LAST   = 2'd2
	} cond_t;

	typedef logic [1:0] step_t;

	localparam step_t STEP_IDLE    = 2'd0;
	localparam step_t STEP_EMIT    = 2'd1;
	localparam step_t STEP_ADVANCE = 2'd2;
	localparam step_t STEP_SPARE   = 2'd3;

	typedef struct packed {
		logic  take_in;
		logic  emit;
		logic  advance;
		cond_t cond;
		step_t target;
	} ctrl_t;

	localparam ctrl_t UCODE [4] = '{
		'{take_in: 1'b1, emit: 1'b0, advance: 1'b0, cond: COND_ACCEPT, target: STEP_EMIT},
		'{take_in: 1'b0, emit: 1'b1, advance: 1'b0, cond: COND_LAST, target: STEP_ADVANCE},
		'{take_in: 1'b0, emit: 1'b0, advance: 1'b1, cond: COND_ALWAYS, target: STEP_IDLE},
		'{take_in: 1'b0, emit: 1'b0, advance: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE}
	};

	// cartesian function count per angular momentum, clamped past 9
	localparam logic [5:0] TRI_CNT [16] = '{
		6'd1, 6'd3, 6'd6, 6'd10, 6'd15, 6'd21, 6'd28, 6'd36,
		6'd45, 6'd55, 6'd55, 6'd55, 6'd55, 6'd55, 6'd55, 6'd55
	};

	localparam logic [3:0] PERM_D [16] = '{
		4'd0, 4'd2, 4'd5, 4'd1, 4'd3, 4'd4, 4'd0, 4'd0,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
	};

	localparam logic [3:0] PERM_F [16] = '{
		4'd0, 4'd3, 4'd9, 4'd2, 4'd1, 4'd4, 4'd7, 4'd8,
		4'd6, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
	};

	localparam logic [3:0] PERM_G [16] = '{
		4'd0, 4'd4, 4'd14, 4'd1, 4'd5, 4'd3, 4'd8, 4'd12,
		4'd13, 4'd2, 4'd9, 4'd11, 4'd6, 4'd7, 4'd10, 4'd0
	};

endpackage

// ----- sv/shell_basis_reorder_index.sv -----
// shell basis reorder index generator, top level
// One input word names a shell; the block then emits one output word per basis
// function of that shell, giving its source index (running basis offset plus the
// permuted position) together with last-of-shell, not-reordered and sticky
// offset-overflow flags. The offset clears on first_shell and wraps at
// 2^INDEX_BITS. Control is a three-step microcode program (accept, emit, advance):
// for a shell of n functions (1 to 55) the emit step produces one output word per
// cycle into the output register while the output side does not stall; a stall
// holds the emit step. A new input word is taken only in the accept step.
`include "shell_basis_reorder_index_defines.svh"

module shell_basis_reorder_index
	import sbri_pkg::*;
#(
	parameter int INDEX_BITS  = 16,
	parameter int MAX_ANGULAR = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [4:0] shell_type,
	input  logic              first_shell,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       basis_index,
	output logic              last_of_shell,
	output logic              not_reordered,
	output logic              offset_overflow
);

	localparam int MAX_RUN  = ((MAX_ANGULAR + 1) * (MAX_ANGULAR + 2)) / 2;
	localparam int CNT_BITS = $clog2(MAX_RUN);

	ctrl_t                 ctrl;
	step_t                 pc_q;
	logic                  accept;
	logic                  fire;
	logic                  last_k;
	logic                  jump;

	logic [4:0]            mag;
	logic [3:0]            l_d;
	mode_t                 mode_d;
	logic [CNT_BITS-1:0]   last_d;
	logic                  nr_d;
	logic [INDEX_BITS-1:0] base;
	logic                  ovf_base;
	logic [INDEX_BITS:0]   span_sum;

	mode_t                 mode_q;
	logic [3:0]            l_q;
	logic [CNT_BITS-1:0]   last_k_q;
	logic [CNT_BITS-1:0]   k_q;
	logic                  nr_q;
	logic                  ovf_q;
	logic [INDEX_BITS-1:0] offset_q;

	logic [REL_BITS-1:0]   k_ext;
	logic [REL_BITS-1:0]   rel;
	logic [INDEX_BITS-1:0] idx;

	logic                  out_valid_q;
	logic [15:0]           basis_index_q;
	logic                  last_q;
	logic                  nr_out_q;
	logic                  ovf_out_q;

	assign ctrl     = UCODE[pc_q];
	assign in_stall = !ctrl.take_in;
	assign accept   = in_valid && ctrl.take_in;
	assign fire     = ctrl.emit && (!out_valid_q || !out_stall);
	assign last_k   = (k_q == last_k_q);

	always_comb begin
		case (ctrl.cond)
			COND_ALWAYS: jump = 1'b1;
			COND_ACCEPT: jump = accept;
			COND_LAST:   jump = fire && last_k;
			default:     jump = 1'b0;
		endcase
	end

	// shell decode at accept
	always_comb begin
		mag    = '0;
		l_d    = '0;
		mode_d = MODE_IDENT;
		last_d = '0;
		nr_d   = 1'b0;
		if (shell_type < TYPE_SP) begin
			mag    = 5'(-shell_type);
			l_d    = (mag > 5'(MAX_ANGULAR)) ? 4'(MAX_ANGULAR) : mag[3:0];
			mode_d = MODE_PURE;
			last_d = CNT_BITS'({l_d, 1'b0});
		end else begin
			case (shell_type)
				TYPE_SP: last_d = CNT_BITS'(3);
				TYPE_S:  last_d = '0;
				TYPE_P:  last_d = CNT_BITS'(2);
				TYPE_D: begin
					mode_d = MODE_D;
					last_d = CNT_BITS'(5);
				end
				TYPE_F: begin
					mode_d = MODE_F;
					last_d = CNT_BITS'(9);
				end
				TYPE_G: begin
					mode_d = MODE_G;
					last_d = CNT_BITS'(14);
				end
				default: begin
					mag    = 5'(shell_type);
					l_d    = (mag > 5'(MAX_ANGULAR)) ? 4'(MAX_ANGULAR) : mag[3:0];
					last_d = CNT_BITS'(TRI_CNT[l_d] - 6'd1);
					nr_d   = 1'b1;
				end
			endcase
		end
	end

	assign base     = first_shell ? '0 : offset_q;
	assign ovf_base = first_shell ? 1'b0 : ovf_q;
	assign span_sum = {1'b0, base} + (INDEX_BITS + 1)'(last_d);

	// relative position of the current word
	assign k_ext = REL_BITS'(k_q);

	always_comb begin
		case (mode_q)
			MODE_PURE: begin
				if (k_q[0]) begin
					rel = REL_BITS'(l_q) + ((k_ext + 1'b1) >> 1);
				end else begin
					rel = REL_BITS'(l_q) - (k_ext >> 1);
				end
			end
			MODE_D:  rel = REL_BITS'(PERM_D[k_q[3:0]]);
			MODE_F:  rel = REL_BITS'(PERM_F[k_q[3:0]]);
			MODE_G:  rel = REL_BITS'(PERM_G[k_q[3:0]]);
			default: rel = k_ext;
		endcase
	end

	assign idx = offset_q + INDEX_BITS'(rel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_IDLE;
			k_q         <= '0;
			offset_q    <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (jump) begin
				pc_q <= ctrl.target;
			end
			if (accept) begin
				k_q   <= '0;
				ovf_q <= ovf_base | span_sum[INDEX_BITS];
				if (first_shell) begin
					offset_q <= '0;
				end
			end
			if (fire) begin
				k_q <= k_q + 1'b1;
			end
			if (ctrl.advance) begin
				offset_q <= offset_q + INDEX_BITS'(last_k_q) + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode_d;
			l_q      <= l_d;
			last_k_q <= last_d;
			nr_q     <= nr_d;
		end
		if (fire) begin
			basis_index_q <= 16'(idx);
			last_q        <= last_k;
			nr_out_q      <= nr_q;
			ovf_out_q     <= ovf_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign basis_index     = basis_index_q;
	assign last_of_shell   = last_q;
	assign not_reordered   = nr_out_q;
	assign offset_overflow = ovf_out_q;

	`SBRI_ASSERT_NEXT(a_accept_enters_emit, accept, pc_q == STEP_EMIT && k_q == '0)
	`SBRI_ASSERT_NEXT(a_last_word_advances, fire && last_k, pc_q == STEP_ADVANCE)
	`SBRI_ASSERT_IMPLY(a_count_in_range, pc_q == STEP_EMIT, k_q <= last_k_q)

endmodule
